// ===== src/ptrl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptrl_pkg;

    localparam int HALF_W = 10;
    localparam int WORD_W = 20;
    localparam int CODE_W = 5;

    localparam int RELOC_ENTRIES_DEFAULT = 1024;

    // Command codes carried in the low five bits of a Y row command word.
    localparam logic [CODE_W-1:0] CMD_ORIGIN  = 5'd0;
    localparam logic [CODE_W-1:0] CMD_STORE   = 5'd1;
    localparam logic [CODE_W-1:0] CMD_APPLY   = 5'd2;
    localparam logic [CODE_W-1:0] CMD_REPEAT  = 5'd4;
    localparam logic [CODE_W-1:0] CMD_PERFORM = 5'd6;

    typedef logic [HALF_W-1:0] half_t;
    typedef logic [WORD_W-1:0] word_t;

endpackage

`default_nettype wire

// ===== src/ptrl_row_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ptrl_row_if;
    logic           valid;
    logic           ready;
    ptrl_pkg::half_t row_data;
    logic           x_mark;
    logic           y_mark;

    modport source (output valid, output row_data, output x_mark, output y_mark,
                    input ready);
    modport sink (input valid, input row_data, input x_mark, input y_mark,
                  output ready);
endinterface

`default_nettype wire

// ===== src/ptrl_word_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ptrl_word_if;
    logic            valid;
    logic            ready;
    ptrl_pkg::word_t instr_word;
    ptrl_pkg::half_t load_address;
    logic            perform_flag;

    modport source (output valid, output instr_word, output load_address,
                    output perform_flag, input ready);
    modport sink (input valid, input instr_word, input load_address,
                  input perform_flag, output ready);
endinterface

`default_nettype wire

// ===== src/punched_tape_relocating_loader_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                                       Notes
// tape      in         row_data[9:0], x_mark, y_mark                 one tape row per transfer
// word      out        instr_word[19:0], load_address[9:0],          zero or one per row
//                      perform_flag
//
// One row is taken per cycle while tape.ready is high; a completed word appears
// in the output register the cycle after its row's transfer. After reset the
// relocation memory is cleared one entry per cycle, with tape.ready held low meanwhile.
// A stalled output register holds its word, and tape.ready follows word.ready
// while a word is waiting. A parameter lookup reads the memory into a register
// that stands in for the accumulator until the next row folds it in.

module punched_tape_relocating_loader_core #(
    parameter int RELOC_ENTRIES = ptrl_pkg::RELOC_ENTRIES_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    ptrl_row_if.sink    tape,
    ptrl_word_if.source word
);

    localparam int AW = $clog2(RELOC_ENTRIES);
    localparam logic [ptrl_pkg::HALF_W:0] ENTRY_LIMIT = (ptrl_pkg::HALF_W + 1)'(RELOC_ENTRIES);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(RELOC_ENTRIES - 1);

    ptrl_pkg::half_t reloc_mem_reg [RELOC_ENTRIES];
    ptrl_pkg::half_t rd_data_reg;

    logic            clearing_reg;
    logic [AW-1:0]   clr_cnt_reg;

    logic            boot_reg, boot_next;
    ptrl_pkg::word_t acc_reg, acc_next;
    ptrl_pkg::half_t addr_reg, addr_next;
    ptrl_pkg::word_t last_cmd_reg, last_cmd_next;
    logic            perform_reg, perform_next;
    logic            pre_flag_reg, pre_flag_next;

    logic            out_valid_reg, out_valid_next;
    ptrl_pkg::word_t out_word_reg;
    ptrl_pkg::half_t out_addr_reg;
    logic            out_perf_reg;

    logic            accept;
    logic            emit;
    ptrl_pkg::word_t eff_acc;
    ptrl_pkg::word_t sum_low;
    ptrl_pkg::word_t cmd;
    ptrl_pkg::half_t cmd_n;
    logic            n_in_range;
    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_waddr;
    ptrl_pkg::half_t mem_wdata;

    assign tape.ready = !clearing_reg && (!out_valid_reg || word.ready);
    assign accept     = tape.valid && tape.ready;

    // A pending lookup result replaces the accumulator, which is zero then.
    assign eff_acc = pre_flag_reg ? {rd_data_reg, ptrl_pkg::HALF_W'(0)} : acc_reg;
    assign sum_low = eff_acc + {ptrl_pkg::HALF_W'(0), tape.row_data};

    always_comb
    begin
        boot_next     = boot_reg;
        acc_next      = acc_reg;
        addr_next     = addr_reg;
        last_cmd_next = last_cmd_reg;
        perform_next  = perform_reg;
        pre_flag_next = pre_flag_reg;
        out_valid_next = out_valid_reg && !word.ready;
        emit          = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = clr_cnt_reg;
        mem_wdata     = '0;
        cmd           = sum_low;
        cmd_n         = sum_low[ptrl_pkg::WORD_W-1:ptrl_pkg::HALF_W];
        n_in_range    = 1'b0;

        if (clearing_reg)
        begin
            mem_we = 1'b1;
        end
        else if (accept)
        begin
            pre_flag_next = 1'b0;
            if (tape.y_mark)
            begin
                acc_next = '0;
                if (boot_reg)
                begin
                    addr_next = sum_low[ptrl_pkg::HALF_W-1:0];
                    boot_next = 1'b0;
                end
                else
                begin
                    if (sum_low[ptrl_pkg::CODE_W-1:0] == ptrl_pkg::CMD_REPEAT)
                    begin
                        cmd = last_cmd_reg;
                    end
                    else
                    begin
                        last_cmd_next = sum_low;
                    end
                    cmd_n      = cmd[ptrl_pkg::WORD_W-1:ptrl_pkg::HALF_W];
                    n_in_range = {1'b0, cmd_n} < ENTRY_LIMIT;
                    case (cmd[ptrl_pkg::CODE_W-1:0])
                        ptrl_pkg::CMD_ORIGIN:
                        begin
                            addr_next = cmd_n;
                        end
                        ptrl_pkg::CMD_STORE:
                        begin
                            mem_we    = n_in_range;
                            mem_waddr = cmd_n[AW-1:0];
                            mem_wdata = addr_reg;
                        end
                        ptrl_pkg::CMD_APPLY:
                        begin
                            mem_re        = n_in_range;
                            pre_flag_next = n_in_range;
                        end
                        ptrl_pkg::CMD_PERFORM:
                        begin
                            perform_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else if (tape.x_mark || boot_reg)
            begin
                acc_next = '0;
                if (!(boot_reg && tape.row_data == '0))
                begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    if (perform_reg)
                    begin
                        perform_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + ptrl_pkg::HALF_W'(1);
                    end
                end
            end
            else
            begin
                acc_next = eff_acc + {tape.row_data, ptrl_pkg::HALF_W'(0)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            boot_reg      <= 1'b1;
            acc_reg       <= '0;
            addr_reg      <= '0;
            last_cmd_reg  <= '0;
            perform_reg   <= 1'b0;
            pre_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ENTRY)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            boot_reg      <= boot_next;
            acc_reg       <= acc_next;
            addr_reg      <= addr_next;
            last_cmd_reg  <= last_cmd_next;
            perform_reg   <= perform_next;
            pre_flag_reg  <= pre_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg <= sum_low;
            out_addr_reg <= addr_reg;
            out_perf_reg <= perform_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            reloc_mem_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= reloc_mem_reg[cmd_n[AW-1:0]];
        end
    end

    assign word.valid        = out_valid_reg;
    assign word.instr_word   = out_word_reg;
    assign word.load_address = out_addr_reg;
    assign word.perform_flag = out_perf_reg;

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !tape.ready)
        else $error("row taken during relocation memory clear");

    a_word_needs_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept))
        else $error("word appeared without a row transfer");

    a_command_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tape.y_mark) |=> !out_valid_reg)
        else $error("command row produced a word");

    a_lookup_after_boot: assert property (@(posedge clk) disable iff (!rst_n)
        pre_flag_reg |-> !boot_reg)
        else $error("parameter lookup pending in bootstrap mode");

    a_perform_holds_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && perform_reg) |=> ($stable(addr_reg) && !perform_reg))
        else $error("performed word advanced the load address");

endmodule

`default_nettype wire
